// ===== rtl/aghw_pkg.sv =====
// Shared types, widths and saturation helpers for the hashed
// AdaGrad weight update block. No dependencies.
package aghw_pkg;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 18;
    localparam int ENTRY_W = 2 * WORD_W;
    localparam int QUOT_W  = 49;
    localparam int ROOT_W  = 50;
    localparam int ITER_W  = 6;
    localparam int DIV_STEPS  = 49;
    localparam int SQRT_STEPS = 25;
    localparam logic [WORD_W-1:0] HASH_MULT_RESET = 32'd27942141;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic calc_idx;
        logic rd_mem;
        logic calc_inc;
        logic calc_sum;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic calc_t;
        logic calc_d;
        logic wb;
    } dp_cmd_t;

    // Datapath status returned to the controller
    typedef struct packed {
        logic clr_last;
        logic skip_root;
    } dp_stat_t;

    // Clamp a signed 64-bit value to signed 32 bits
    function automatic logic [WORD_W-1:0] sat_s32(input logic signed [63:0] v);
        logic [WORD_W-1:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    // Clamp an unsigned 64-bit value to unsigned 32 bits
    function automatic logic [WORD_W-1:0] sat_u32(input logic [63:0] v);
        logic [WORD_W-1:0] r;
        if (v[63:WORD_W] != '0)
            r = '1;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/adagrad_hashed_weight_update.sv =====
// Hashed AdaGrad weight update. After reset a clearing pass zeroes
// the table; no item is taken meanwhile. When the root is needed, an
// item passes through the restoring divider and then the bit-pair square
// root; both are skipped for a zero update or zero sum. One item is in work
// at a time, so no new item is taken before the last is written back; the output
// register lets the next item start while a result waits. Depends on aghw_pkg,
// aghw_ctrl, aghw_dp.
module adagrad_hashed_weight_update #(
    parameter int TABLE_BITS = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [aghw_pkg::WORD_W-1:0]         pwdata,
    output logic [aghw_pkg::WORD_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [aghw_pkg::WORD_W-1:0]         first_index,
    input  logic signed [aghw_pkg::WORD_W-1:0]  first_value,
    input  logic [aghw_pkg::WORD_W-1:0]         second_index,
    input  logic signed [aghw_pkg::WORD_W-1:0]  second_value,
    input  logic signed [aghw_pkg::WORD_W-1:0]  update_step,
    input  logic [aghw_pkg::WORD_W-1:0]         grad_scale,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [aghw_pkg::INDEX_W-1:0]        entry_index,
    output logic signed [aghw_pkg::WORD_W-1:0]  new_weight,
    output logic [aghw_pkg::WORD_W-1:0]         new_grad_sum
);
    import aghw_pkg::*;

    logic [WORD_W-1:0] hash_mult_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    assign pready = 1'b1;

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mult_reg <= HASH_MULT_RESET;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            hash_mult_reg <= pwdata;
        end
    end

    // Register read
    assign prdata = paddr[2] ? '0 : hash_mult_reg;

    aghw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    aghw_dp #(
        .TABLE_BITS(TABLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .hash_mult   (hash_mult_reg),
        .op          (op),
        .first_index (first_index),
        .first_value (first_value),
        .second_index(second_index),
        .second_value(second_value),
        .update_step (update_step),
        .grad_scale  (grad_scale),
        .entry_index (entry_index),
        .new_weight  (new_weight),
        .new_grad_sum(new_grad_sum)
    );

endmodule

// ===== rtl/aghw_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module aghw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/aghw_ctrl.sv =====
// Controller state machine for the hashed AdaGrad update.
// Depends on aghw_pkg for command and status types.
module aghw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  aghw_pkg::dp_stat_t stat,
    output aghw_pkg::dp_cmd_t  cmd
);
    import aghw_pkg::*;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_IDX  = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_INC  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_SQI  = 4'd7;
    localparam logic [3:0] ST_SQ   = 4'd8;
    localparam logic [3:0] ST_T    = 4'd9;
    localparam logic [3:0] ST_D    = 4'd10;
    localparam logic [3:0] ST_WB   = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_IDX;
                end
            end
            ST_IDX:
            begin
                cmd.calc_idx = 1'b1;
                state_next   = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd_mem = 1'b1;
                state_next = ST_INC;
            end
            ST_INC:
            begin
                cmd.calc_inc = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                cnt_next     = '0;
                if (stat.skip_root)
                    state_next = ST_WB;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(DIV_STEPS - 1))
                    state_next = ST_SQI;
            end
            ST_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(SQRT_STEPS - 1))
                    state_next = ST_T;
            end
            ST_T:
            begin
                cmd.calc_t = 1'b1;
                state_next = ST_D;
            end
            ST_D:
            begin
                cmd.calc_d = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    cmd.wb         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/aghw_dp.sv =====
// Datapath for the hashed AdaGrad update: index hash, products,
// restoring divider, bit-pair square root and the entry table.
// Depends on aghw_pkg and aghw_ram.
module aghw_dp #(
    parameter int TABLE_BITS = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aghw_pkg::dp_cmd_t             cmd,
    output aghw_pkg::dp_stat_t            stat,
    input  logic [aghw_pkg::WORD_W-1:0]   hash_mult,
    input  logic                          op,
    input  logic [aghw_pkg::WORD_W-1:0]   first_index,
    input  logic signed [aghw_pkg::WORD_W-1:0] first_value,
    input  logic [aghw_pkg::WORD_W-1:0]   second_index,
    input  logic signed [aghw_pkg::WORD_W-1:0] second_value,
    input  logic signed [aghw_pkg::WORD_W-1:0] update_step,
    input  logic [aghw_pkg::WORD_W-1:0]   grad_scale,
    output logic [aghw_pkg::INDEX_W-1:0]  entry_index,
    output logic signed [aghw_pkg::WORD_W-1:0] new_weight,
    output logic [aghw_pkg::WORD_W-1:0]   new_grad_sum
);
    import aghw_pkg::*;

    // Item registers
    logic                     op_reg;
    logic [WORD_W-1:0]        i1_reg, i2_reg, g_reg;
    logic signed [WORD_W-1:0] v1_reg, v2_reg, upd_reg;

    // Working registers
    logic [TABLE_BITS-1:0]    idx_reg;
    logic signed [WORD_W-1:0] x_reg, t_reg, old_w_reg;
    logic [WORD_W-1:0]        xsq_reg, inc_reg, sum_reg;
    logic signed [47:0]       delta_reg;
    logic [WORD_W-1:0]        rem_reg;
    logic [QUOT_W-1:0]        quot_reg, dvd_reg;
    logic [ROOT_W-1:0]        rad_reg, root_reg;
    logic [QUOT_W-1:0]        bit_reg;
    logic [TABLE_BITS-1:0]    clr_reg;

    // Output registers
    logic [INDEX_W-1:0]       eidx_reg;
    logic [WORD_W-1:0]        nw_reg, ns_reg;

    // Combinational terms
    logic [WORD_W-1:0]        hprod;
    logic [WORD_W-1:0]        hsum;
    logic signed [63:0]       pprod, tprod, dprod, wsum;
    logic [WORD_W-1:0]        ax;
    logic [63:0]              sqprod, gprod;
    logic [WORD_W:0]          sum_add;
    logic [WORD_W-1:0]        sum_c, old_sum, sum_sel;
    logic [WORD_W:0]          shifted;
    logic                     ge;
    logic [ROOT_W-1:0]        rb;
    logic [ENTRY_W-1:0]       rdata, wdata;
    logic                     ram_we;
    logic [TABLE_BITS-1:0]    ram_addr;

    assign hprod   = hash_mult * i1_reg;
    assign hsum    = hprod + i2_reg;
    assign pprod   = 64'(v1_reg) * 64'(v2_reg);
    assign ax      = x_reg[WORD_W-1] ? WORD_W'(-x_reg) : x_reg;
    assign sqprod  = 64'(ax) * 64'(ax);
    assign gprod   = 64'(g_reg) * 64'(xsq_reg);
    assign old_sum = rdata[WORD_W-1:0];
    assign sum_add = {1'b0, old_sum} + {1'b0, inc_reg};
    assign sum_c   = sum_add[WORD_W] ? '1 : sum_add[WORD_W-1:0];
    assign sum_sel = (upd_reg == '0) ? old_sum : sum_c;
    assign shifted = {rem_reg, dvd_reg[QUOT_W-1]};
    assign ge      = (shifted >= {1'b0, sum_reg});
    assign rb      = root_reg + ROOT_W'(bit_reg);
    assign tprod   = 64'(x_reg) * $signed({39'd0, root_reg[24:0]});
    assign dprod   = 64'(upd_reg) * 64'(t_reg);
    assign wsum    = 64'(old_w_reg) + 64'(delta_reg);

    // Root is skipped for a zero update or a zero sum
    assign stat.skip_root = (upd_reg == '0) || (sum_c == '0);
    assign stat.clr_last  = (clr_reg == '1);

    // Clear sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= op;
            i1_reg  <= first_index;
            v1_reg  <= first_value;
            i2_reg  <= second_index;
            v2_reg  <= second_value;
            upd_reg <= update_step;
            g_reg   <= grad_scale;
        end
        if (cmd.calc_idx)
        begin
            if (op_reg)
            begin
                idx_reg <= hsum[TABLE_BITS-1:0];
                x_reg   <= sat_s32(pprod >>> 16);
            end
            else
            begin
                idx_reg <= i1_reg[TABLE_BITS-1:0];
                x_reg   <= v1_reg;
            end
        end
        if (cmd.rd_mem)
        begin
            xsq_reg <= sat_u32(sqprod >> 16);
        end
        if (cmd.calc_inc)
        begin
            inc_reg <= sat_u32(gprod >> 16);
        end
        if (cmd.calc_sum)
        begin
            sum_reg   <= sum_sel;
            old_w_reg <= rdata[ENTRY_W-1:WORD_W];
            delta_reg <= '0;
            rem_reg   <= '0;
            quot_reg  <= '0;
            dvd_reg   <= {1'b1, {(QUOT_W-1){1'b0}}};
        end
        // One quotient bit of 2^48 / sum
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? WORD_W'(shifted - {1'b0, sum_reg}) : shifted[WORD_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dvd_reg  <= {dvd_reg[QUOT_W-2:0], 1'b0};
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= ROOT_W'(quot_reg);
            root_reg <= '0;
            bit_reg  <= {1'b1, {(QUOT_W-1){1'b0}}};
        end
        // One root bit per step
        if (cmd.sqrt_step)
        begin
            if (rad_reg >= rb)
            begin
                rad_reg  <= rad_reg - rb;
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.calc_t)
        begin
            t_reg <= sat_s32(tprod >>> 16);
        end
        if (cmd.calc_d)
        begin
            delta_reg <= dprod[63:16];
        end
        if (cmd.wb)
        begin
            eidx_reg <= INDEX_W'(idx_reg);
            nw_reg   <= sat_s32(wsum);
            ns_reg   <= sum_reg;
        end
    end

    // Table port: clear sweep, read, write back
    assign ram_we   = cmd.clr_step || cmd.wb;
    assign ram_addr = cmd.clr_step ? clr_reg : idx_reg;
    assign wdata    = cmd.clr_step ? '0 : {sat_s32(wsum), sum_reg};

    aghw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(2 ** TABLE_BITS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .re   (cmd.rd_mem),
        .addr (ram_addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    assign entry_index  = eidx_reg;
    assign new_weight   = nw_reg;
    assign new_grad_sum = ns_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for adagrad_hashed_weight_update: directed table, then random
// sparse features under bursty input and receiver stalls, checked by an in-bench predictor.
// Depends on aghw_pkg and the block's RTL only.
module tb_top;
    import aghw_pkg::*;

    localparam logic [2:0] ADDR_HASH_MULT = 3'd0;
    localparam logic [2:0] ADDR_SPARE     = 3'd4;
    localparam logic       OP_LINEAR      = 1'b0;
    localparam logic       OP_PAIR        = 1'b1;
    localparam int         IDX_BITS       = 18;
    localparam int         LIMIT_CYCLES   = 4000000;
    localparam int         TAIL_CYCLES    = 100;

    typedef struct packed {
        logic        op;
        logic [31:0] i1;
        logic [31:0] v1;
        logic [31:0] i2;
        logic [31:0] v2;
        logic [31:0] upd;
        logic [31:0] g;
    } feature_t;

    typedef struct packed {
        logic [17:0] idx;
        logic [31:0] w;
        logic [31:0] s;
    } entry_t;

    typedef struct packed {
        feature_t f;
        logic     typed;
        entry_t   e;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic [31:0] first_index = '0, second_index = '0, grad_scale = '0;
    logic signed [31:0] first_value = '0, second_value = '0, update_step = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [17:0] entry_index;
    logic signed [31:0] new_weight;
    logic [31:0] new_grad_sum;

    adagrad_hashed_weight_update uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .first_index(first_index), .first_value(first_value),
        .second_index(second_index), .second_value(second_value),
        .update_step(update_step), .grad_scale(grad_scale),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_index(entry_index), .new_weight(new_weight), .new_grad_sum(new_grad_sum)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: sparse copy of the table's weights and sums plus the multiplier
    logic [31:0] weight_mem [int unsigned];
    logic [31:0] sum_mem [int unsigned];
    logic [31:0] pair_mult = HASH_MULT_RESET;
    entry_t      pending_entries [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;

    function automatic longint clamp_signed(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned clamp_unsigned(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Apply one feature to the table copy and return the updated entry
    function automatic entry_t adagrad_update(input feature_t f);
        logic [31:0] hashed;
        logic [17:0] idx;
        longint x, ax, r, t, delta, w_old;
        longint unsigned xsq, inc, sum;
        entry_t e;
        hashed = pair_mult * f.i1 + f.i2;
        idx = (f.op == OP_PAIR) ? hashed[IDX_BITS-1:0] : f.i1[IDX_BITS-1:0];
        if (f.op == OP_PAIR)
            x = clamp_signed((longint'($signed(f.v1)) * longint'($signed(f.v2))) >>> 16);
        else
            x = longint'($signed(f.v1));
        if (!weight_mem.exists(idx))
        begin
            weight_mem[idx] = '0;
            sum_mem[idx] = '0;
        end
        if (f.upd != 0)
        begin
            ax = (x < 0) ? -x : x;
            xsq = clamp_unsigned(longint'(ax * ax) >> 16);
            inc = clamp_unsigned((longint'(f.g) * xsq) >> 16);
            sum = clamp_unsigned(longint'(sum_mem[idx]) + inc);
            sum_mem[idx] = sum[31:0];
            delta = 0;
            if (sum != 0)
            begin
                r = int_sqrt((64'd1 << 48) / sum);
                t = clamp_signed((x * r) >>> 16);
                delta = (longint'($signed(f.upd)) * t) >>> 16;
            end
            w_old = longint'($signed(weight_mem[idx]));
            weight_mem[idx] = 32'(clamp_signed(w_old + delta));
        end
        e.idx = idx;
        e.w = weight_mem[idx];
        e.s = sum_mem[idx];
        return e;
    endfunction

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_HASH_MULT)
            pair_mult = data;
    endtask

    // Hold until every expected entry has come back
    task automatic drain;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Present one item, with a random gap between bursts; record its entry on acceptance
    task automatic send_feature(input feature_t f, input logic typed, input entry_t e_typed);
        int gap;
        entry_t e;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        op <= f.op;
        first_index <= f.i1;
        first_value <= f.v1;
        second_index <= f.i2;
        second_value <= f.v2;
        update_step <= f.upd;
        grad_scale <= f.g;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        e = adagrad_update(f);
        pending_entries.push_back(typed ? e_typed : e);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(0, 32'h0003_0000);
            2: return -$urandom_range(0, 32'h0003_0000);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic feature_t rand_feature();
        feature_t f;
        f.op = 1'($urandom_range(0, 1));
        // Reuse a small pool of low index bits so entries accumulate
        f.i1 = $urandom;
        if ($urandom_range(0, 1))
            f.i1[IDX_BITS-1:0] = IDX_BITS'($urandom_range(0, 31));
        f.i2 = $urandom;
        if ($urandom_range(0, 1))
            f.i2 = $urandom_range(0, 15);
        f.v1 = rand_value();
        f.v2 = rand_value();
        f.upd = ($urandom_range(0, 9) == 0) ? '0 : rand_value();
        case ($urandom_range(0, 3))
            0: f.g = $urandom_range(0, 32'h0002_0000);
            1: f.g = 32'hFFFF_FFFF;
            default: f.g = $urandom;
        endcase
        return f;
    endfunction

    // Receiver: stall pattern steps through four modes as the cycle count advances
    always @(posedge clk)
    begin
        entry_t exp_e;
        cycles <= cycles + 1;
        if (out_valid && !out_stall)
        begin
            if (pending_entries.size() == 0)
            begin
                $display("%0t: unexpected result idx=%h w=%h s=%h", $time,
                         entry_index, new_weight, new_grad_sum);
                errors++;
            end
            else
            begin
                exp_e = pending_entries.pop_front();
                if (entry_index !== exp_e.idx)
                begin
                    $display("%0t: entry_index expected %h actual %h", $time,
                             exp_e.idx, entry_index);
                    errors++;
                end
                if (new_weight !== exp_e.w)
                begin
                    $display("%0t: new_weight expected %h actual %h", $time,
                             exp_e.w, new_weight);
                    errors++;
                end
                if (new_grad_sum !== exp_e.s)
                begin
                    $display("%0t: new_grad_sum expected %h actual %h", $time,
                             exp_e.s, new_grad_sum);
                    errors++;
                end
            end
        end
        case (cycles[9:8])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 9) < 3);
            2'd2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= cycles[2];
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    stim_row_t directed [13];
    logic [31:0] mults [4];

    initial
    begin
        entry_t none;
        none = '0;
        directed[0]  = '{'{OP_LINEAR, 32'd5, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000},
                         1'b1, '{18'd5, 32'd0, 32'd0}};
        directed[1]  = '{'{OP_LINEAR, 32'd7, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                           32'h0001_0000}, 1'b1, '{18'd7, 32'h0001_0000, 32'h0001_0000}};
        directed[2]  = '{'{OP_LINEAR, 32'd9, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF},
                         1'b1, '{18'd9, 32'd0, 32'd0}};
        directed[3]  = '{'{OP_LINEAR, 32'd7, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                           32'h0001_0000}, 1'b0, none};
        directed[4]  = '{'{OP_LINEAR, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, none};
        directed[5]  = '{'{OP_LINEAR, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h8000_0000,
                           32'hFFFF_FFFF}, 1'b0, none};
        directed[6]  = '{'{OP_PAIR, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'd1}, 1'b0, none};
        directed[7]  = '{'{OP_PAIR, 32'd1, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'h8000_0000,
                           32'hFFFF_FFFF}, 1'b0, none};
        directed[8]  = '{'{OP_PAIR, 32'd3, 32'h8000_0000, 32'd5, 32'h7FFF_FFFF, 32'h0001_0000,
                           32'h0001_0000}, 1'b0, none};
        directed[9]  = '{'{OP_PAIR, 32'd3, 32'h0001_0000, 32'd5, 32'h0001_0000, 32'd0,
                           32'h0001_0000}, 1'b0, none};
        directed[10] = '{'{OP_LINEAR, 32'h0003_FFFF, 32'hFFFF_0000, 32'd0, 32'd0, 32'hFFFF_0000,
                           32'h0000_8000}, 1'b0, none};
        directed[11] = '{'{OP_PAIR, 32'h1234_5678, 32'h0000_8000, 32'h9ABC_DEF0, 32'h0000_8000,
                           32'h0000_4000, 32'h0004_0000}, 1'b0, none};
        directed[12] = '{'{OP_LINEAR, 32'h0004_0000, 32'd1, 32'd0, 32'd0, 32'd1, 32'd1},
                         1'b0, none};
        mults[0] = 32'hFFFF_FFFF;
        mults[1] = 32'd0;
        mults[2] = $urandom;
        mults[3] = HASH_MULT_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Out-of-range register write must leave the multiplier alone
        reg_write(ADDR_SPARE, $urandom);
        @(posedge clk);
        foreach (directed[k])
            send_feature(directed[k].f, directed[k].typed, directed[k].e);
        in_valid <= 1'b0;

        // Random phases, one multiplier setting each
        foreach (mults[p])
        begin
            drain();
            reg_write(ADDR_HASH_MULT, mults[p]);
            @(posedge clk);
            for (int n = 0; n < 470; n++)
                send_feature(rand_feature(), 1'b0, none);
            in_valid <= 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
